@@ src/vsf_pkg.sv @@
// vsf_pkg: shared types and codes for the vertex split forest front.
// No dependencies; used by vsf_req_check and vertex_split_forest_front.
package vsf_pkg;

  localparam int VTX_W = 10;
  localparam int CNT_W = 11;
  localparam int CFG_W = 11;
  localparam int ST_W  = 3;

  localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 11'd1024;
  localparam logic [CNT_W-1:0] COUNT_MAX          = 11'd2047;

  localparam logic [ST_W-1:0] ST_DONE       = 3'd0;
  localparam logic [ST_W-1:0] ST_RANGE      = 3'd1;
  localparam logic [ST_W-1:0] ST_REFINED    = 3'd2;
  localparam logic [ST_W-1:0] ST_INACTIVE   = 3'd3;
  localparam logic [ST_W-1:0] ST_DEPENDENTS = 3'd4;
  localparam logic [ST_W-1:0] ST_FULL       = 3'd5;
  localparam logic [ST_W-1:0] ST_SKIPPED    = 3'd6;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_REFINE  = 2'd1,
    REQ_COARSEN = 2'd2,
    REQ_QUERY   = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [VTX_W-1:0]   split_index;
    logic [VTX_W-1:0]   query_vertex;
    logic [VTX_W-1:0]   parent_vertex;
    logic [VTX_W-1:0]   child_vertex;
    logic [VTX_W-1:0]   left_apex;
    logic               has_left_apex;
    logic [VTX_W-1:0]   right_apex;
    logic               has_right_apex;
  } req_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VTX_W-1:0] result_value;
  } rsp_item_t;

  typedef struct packed {
    logic [VTX_W-1:0] parent;
    logic [VTX_W-1:0] child;
    logic [VTX_W-1:0] vl;
    logic [VTX_W-1:0] vr;
    logic             has_vr;
    logic             refined;
  } split_entry_t;

  // precheck results of an incoming request
  typedef struct packed {
    logic [ST_W-1:0] load_status;
    logic            split_range;
    logic            query_range;
  } chk_t;

endpackage

@@ src/vertex_split_forest_front.sv @@
// vertex_split_forest_front: split table, vertex state memory and request sequencer.
// Depends on vsf_pkg and vsf_req_check.
//
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_item_t (request fields)
// rsp     | out       | rsp_valid/rsp_ready  | rsp_item_t (status, result_value)
// cfg     | in        | cfg_valid/cfg_ready  | cfg_data (vertex_count)
//
// A query walks the parent links, one per S_QV/S_QS pass, and a rejected request goes
// straight to S_OUT. Each read-modify-write of a vertex reads in S_UPR and writes in S_UPW.
// After reset a clearing pass over all MAX_VERTICES entries sets every vertex active with no
// link and no dependents; req_ready stays low during it, cfg writes are taken throughout.
// A finished result sits in the rsp register; the next request is taken while it waits.
module vertex_split_forest_front #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_SPLITS   = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  vsf_pkg::req_item_t            req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output vsf_pkg::rsp_item_t            rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vsf_pkg::CFG_W-1:0]     cfg_data
);
  import vsf_pkg::*;

  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int SIW = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1;
  localparam int STW = $clog2(MAX_SPLITS + 1);
  localparam int SPW = $clog2(MAX_VERTICES + 1);

  // per-vertex state word
  typedef struct packed {
    logic             active;
    logic             link_ok;
    logic [SIW-1:0]   link;
    logic [CNT_W-1:0] count;
  } vtx_entry_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LDW, S_SPL, S_CHK, S_CCHK, S_UPR, S_UPW, S_QV, S_QS, S_OUT
  } state_t;

  // memories
  vtx_entry_t   vmem [MAX_VERTICES];
  split_entry_t smem [MAX_SPLITS];

  vtx_entry_t     vrd, vwdata;
  logic [VIW-1:0] vaddr, vwaddr;
  logic           vwe;
  split_entry_t   srd, swdata;
  logic [SIW-1:0] saddr, swaddr;
  logic           swe;

  state_t           state;
  logic [VIW-1:0]   clr_cnt;
  logic [CFG_W-1:0] vertex_count;
  logic [STW-1:0]   total;
  req_item_t        cur;
  split_entry_t     ent;
  logic [SIW-1:0]   sidx;
  logic [1:0]       k;          // check / update step
  logic [VTX_W-1:0] qv_cur;
  logic [SPW-1:0]   steps;
  logic [ST_W-1:0]  res_status;
  logic [VTX_W-1:0] res_value;

  chk_t             chk;
  logic             refine_op;
  logic [VTX_W-1:0] upd_vtx;
  logic             upd_last;

  vsf_req_check #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_SPLITS   (MAX_SPLITS)
  ) u_check (
    .req          (req),
    .vertex_count (vertex_count),
    .total        (total),
    .chk          (chk)
  );

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign refine_op = (cur.req_type == REQ_REFINE);

  // vertex touched at update step k: child, parent, left apex, right apex
  always_comb begin
    unique case (k)
      2'd0: upd_vtx = ent.child;
      2'd1: upd_vtx = ent.parent;
      2'd2: upd_vtx = ent.vl;
      2'd3: upd_vtx = ent.vr;
      default: upd_vtx = ent.child;
    endcase
  end
  assign upd_last = (k == 2'd3) || ((k == 2'd2) && !ent.has_vr);

  always_ff @(posedge clk) begin
    if (vwe) vmem[vwaddr] <= vwdata;
    vrd <= vmem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (swe) smem[swaddr] <= swdata;
    srd <= smem[saddr];
  end

  // memory port control
  always_comb begin
    vaddr  = '0;
    vwe    = 1'b0;
    vwaddr = VIW'(upd_vtx);
    vwdata = vrd;
    saddr  = sidx;
    swe    = 1'b0;
    swaddr = sidx;
    swdata = ent;
    unique case (state)
      S_CLR: begin
        vwe            = 1'b1;
        vwaddr         = clr_cnt;
        vwdata         = '0;
        vwdata.active  = 1'b1;
      end
      S_IDLE: begin
        vaddr = (req.req_type == REQ_LOAD) ? VIW'(req.child_vertex) : VIW'(req.query_vertex);
        saddr = SIW'(req.split_index);
        // new split goes in at the accepting edge
        swe    = req_valid && (req.req_type == REQ_LOAD) && (chk.load_status == ST_DONE);
        swaddr = SIW'(total);
        swdata.parent  = req.parent_vertex;
        swdata.child   = req.child_vertex;
        swdata.vl      = req.left_apex;
        swdata.vr      = req.has_right_apex ? req.right_apex : '0;
        swdata.has_vr  = req.has_right_apex;
        swdata.refined = 1'b0;
      end
      S_LDW: begin
        vwe            = 1'b1;
        vwaddr         = VIW'(cur.child_vertex);
        vwdata.active  = 1'b0;
        vwdata.link_ok = 1'b1;
        vwdata.link    = SIW'(total);
      end
      S_SPL: begin
        vaddr = refine_op ? VIW'(srd.parent) : VIW'(srd.child);
      end
      S_CHK: begin
        vaddr = (k == 2'd0) ? VIW'(ent.vl) : VIW'(ent.vr);
      end
      S_CCHK: begin
      end
      S_UPR: begin
        vaddr          = VIW'(upd_vtx);
        swe            = (k == 2'd0);
        swdata.refined = refine_op;
      end
      S_UPW: begin
        vwe = 1'b1;
        if (k == 2'd0) begin
          vwdata.active = refine_op;
        end else if (refine_op) begin
          if (vrd.count != COUNT_MAX) vwdata.count = vrd.count + 1'b1;
        end else begin
          if (vrd.count != '0) vwdata.count = vrd.count - 1'b1;
        end
      end
      S_QV: begin
        saddr = vrd.link;
      end
      S_QS: begin
        vaddr = VIW'(srd.parent);
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_cnt      <= '0;
      vertex_count <= VERTEX_COUNT_RESET;
      total        <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_valid) vertex_count <= cfg_data;
      // S_OUT refills the register itself when the old result leaves
      if (rsp_valid && rsp_ready && (state != S_OUT)) rsp_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == VIW'(MAX_VERTICES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            cur       <= req;
            sidx      <= SIW'(req.split_index);
            qv_cur    <= req.query_vertex;
            steps     <= '0;
            k         <= 2'd0;
            res_value <= '0;
            unique case (req.req_type)
              REQ_LOAD: begin
                if (chk.load_status == ST_DONE) begin
                  state <= S_LDW;
                end else begin
                  res_status <= chk.load_status;
                  state      <= S_OUT;
                end
              end
              REQ_REFINE, REQ_COARSEN: begin
                if (chk.split_range) begin
                  res_status <= ST_RANGE;
                  state      <= S_OUT;
                end else begin
                  state <= S_SPL;
                end
              end
              REQ_QUERY: begin
                if (chk.query_range) begin
                  res_status <= ST_RANGE;
                  state      <= S_OUT;
                end else begin
                  state <= S_QV;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LDW: begin
          total      <= total + 1'b1;
          res_status <= ST_DONE;
          res_value  <= VTX_W'(total);
          state      <= S_OUT;
        end
        S_SPL: begin
          ent <= srd;
          if (srd.refined == refine_op) begin
            res_status <= ST_REFINED;
            state      <= S_OUT;
          end else begin
            state <= refine_op ? S_CHK : S_CCHK;
          end
        end
        S_CHK: begin
          if (!vrd.active) begin
            res_status <= ST_INACTIVE;
            state      <= S_OUT;
          end else if (k == 2'd0 || (k == 2'd1 && ent.has_vr)) begin
            k <= k + 1'b1;
          end else begin
            k     <= 2'd0;
            state <= S_UPR;
          end
        end
        S_CCHK: begin
          if (vrd.count != '0) begin
            res_status <= ST_DEPENDENTS;
            state      <= S_OUT;
          end else begin
            state <= S_UPR;
          end
        end
        S_UPR: state <= S_UPW;
        S_UPW: begin
          if (upd_last) begin
            res_status <= ST_DONE;
            state      <= S_OUT;
          end else begin
            k     <= k + 1'b1;
            state <= S_UPR;
          end
        end
        S_QV: begin
          if (vrd.active) begin
            res_status <= ST_DONE;
            res_value  <= qv_cur;
            state      <= S_OUT;
          end else if (!vrd.link_ok || (32'(vrd.link) >= 32'(total)) ||
                       (32'(steps) >= MAX_VERTICES)) begin
            res_status <= ST_INACTIVE;
            state      <= S_OUT;
          end else begin
            state <= S_QS;
          end
        end
        S_QS: begin
          qv_cur <= srd.parent;
          steps  <= steps + 1'b1;
          state  <= S_QV;
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.status        <= res_status;
            rsp.result_value  <= res_value;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the table never grows past its depth
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= MAX_SPLITS)
    else $error("split total beyond table depth");

  // a completed load adds exactly one split
  a_load_inc: assert property (@(posedge clk) disable iff (rst)
    (state == S_LDW) |=> (total == STW'($past(total) + 1'b1)))
    else $error("load did not advance split total");

  // parent walk is bounded
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_QV) |-> (32'(steps) <= MAX_VERTICES))
    else $error("ancestor walk overran");

  // no request taken while the vertex memory is being cleared
  a_clr_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !req_ready)
    else $error("request accepted during clearing pass");

endmodule

@@ src/vsf_req_check.sv @@
// vsf_req_check: range, skip and table-full checks on an incoming request.
// Depends on vsf_pkg.
module vsf_req_check #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_SPLITS   = 1024
) (
  input  vsf_pkg::req_item_t               req,
  input  logic [vsf_pkg::CFG_W-1:0]        vertex_count,
  input  logic [$clog2(MAX_SPLITS+1)-1:0]  total,
  output vsf_pkg::chk_t                    chk
);
  import vsf_pkg::*;

  function automatic logic out_of_range(input logic [VTX_W-1:0] v,
                                        input logic [CFG_W-1:0] cnt);
    return ({1'b0, v} >= cnt) || (32'(v) >= MAX_VERTICES);
  endfunction

  always_comb begin
    chk.split_range = 32'(req.split_index) >= 32'(total);
    chk.query_range = out_of_range(req.query_vertex, vertex_count);
    priority if (!req.has_left_apex) begin
      chk.load_status = ST_SKIPPED;
    end else if (out_of_range(req.parent_vertex, vertex_count) ||
                 out_of_range(req.child_vertex, vertex_count) ||
                 out_of_range(req.left_apex, vertex_count) ||
                 (req.has_right_apex && out_of_range(req.right_apex, vertex_count))) begin
      chk.load_status = ST_RANGE;
    end else if (32'(total) >= MAX_SPLITS) begin
      chk.load_status = ST_FULL;
    end else begin
      chk.load_status = ST_DONE;
    end
  end

endmodule
